// ===== rtl/bpr_pkg.sv =====
// Shared constants and types for the button press and repeat event block.
package bpr_pkg;

    localparam int BUTTON_COUNT = 16;
    localparam int PAD_COUNT    = 2;
    localparam int TIMER_BITS   = 16;

    localparam int PAD_W  = 1;
    localparam int MASK_W = 16;
    localparam int DT_W   = 8;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 1;

    localparam int PAD_IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int TSUM_W    = TIMER_BITS + 1;
    localparam int CMP_W     = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int OUT_LANES = (BUTTON_COUNT < MASK_W) ? BUTTON_COUNT : MASK_W;
    localparam int IN_LANES  = (BUTTON_COUNT < MASK_W) ? BUTTON_COUNT : MASK_W;

    localparam int IN_BITS  = MASK_W + DT_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 5 * MASK_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] REG_LONG_PRESS_TIME = 1'b0;
    localparam logic [IDX_W-1:0] REG_REPEAT_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_RESET     = 16'd100;

    typedef struct packed {
        logic push;
        logic press;
        logic long_press;
        logic repeat_hit;
        logic release_hit;
    } t_lane_ev;

endpackage

// ===== rtl/bpr_lane.sv =====
// One button lane: edge detect, long-press and repeat timers for every pad.
module bpr_lane (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_load,
    input  logic                                  i_pad_ok,
    input  logic [bpr_pkg::PAD_IDX_W-1:0]         i_pad_idx,
    input  logic                                  i_now,
    input  logic [bpr_pkg::DT_W-1:0]              i_dt,
    input  logic [bpr_pkg::CFG_W-1:0]             i_long_time,
    input  logic [bpr_pkg::CFG_W-1:0]             i_rep_int,
    output bpr_pkg::t_lane_ev                     o_ev
);

    logic [bpr_pkg::PAD_COUNT-1:0]  r_prev;
    logic [bpr_pkg::PAD_COUNT-1:0]  r_hrun;
    logic [bpr_pkg::PAD_COUNT-1:0]  r_rrun;
    logic [bpr_pkg::TIMER_BITS-1:0] r_hold [bpr_pkg::PAD_COUNT];
    logic [bpr_pkg::TIMER_BITS-1:0] r_rep  [bpr_pkg::PAD_COUNT];

    logic                           was, hrun, rrun, rrun_mid;
    logic                           rise, held, fall, long_hit, rep_hit;
    logic [bpr_pkg::TIMER_BITS-1:0] hold_old, rep_old, hold_acc, rep_acc, rep_mid;
    logic [bpr_pkg::TIMER_BITS-1:0] n_hold, n_rep;
    logic [bpr_pkg::TSUM_W-1:0]     hold_sum, rep_sum;

    always_comb begin
        was      = r_prev[i_pad_idx];
        hrun     = r_hrun[i_pad_idx];
        rrun     = r_rrun[i_pad_idx];
        hold_old = r_hold[i_pad_idx];
        rep_old  = r_rep[i_pad_idx];

        rise = i_pad_ok & ~was & i_now;
        held = i_pad_ok & was & i_now;
        fall = i_pad_ok & was & ~i_now;

        hold_sum = {1'b0, hold_old} + bpr_pkg::TSUM_W'(i_dt);
        rep_sum  = {1'b0, rep_old} + bpr_pkg::TSUM_W'(i_dt);
        hold_acc = hold_sum[bpr_pkg::TIMER_BITS] ? '1 : hold_sum[bpr_pkg::TIMER_BITS-1:0];
        rep_acc  = rep_sum[bpr_pkg::TIMER_BITS] ? '1 : rep_sum[bpr_pkg::TIMER_BITS-1:0];
        if (!hrun) begin
            hold_acc = hold_old;
        end
        if (!rrun) begin
            rep_acc = rep_old;
        end

        long_hit = held & hrun &
                   (bpr_pkg::CMP_W'(hold_acc) >= bpr_pkg::CMP_W'(i_long_time));
        rrun_mid = rrun | long_hit;
        rep_mid  = long_hit ? '0 : rep_acc;
        rep_hit  = held & rrun_mid &
                   (bpr_pkg::CMP_W'(rep_mid) >= bpr_pkg::CMP_W'(i_rep_int));

        n_hold = rise ? '0 : hold_acc;
        n_rep  = rep_hit ? '0 : rep_mid;

        o_ev.push        = rise;
        o_ev.press       = rise | held;
        o_ev.long_press  = long_hit;
        o_ev.repeat_hit  = rep_hit;
        o_ev.release_hit = fall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_hrun <= '0;
            r_rrun <= '0;
        end else if (i_load && i_pad_ok) begin
            r_prev[i_pad_idx] <= i_now;
            if (rise) begin
                r_hrun[i_pad_idx] <= 1'b1;
            end else if (held) begin
                r_hrun[i_pad_idx] <= hrun & ~long_hit;
                r_rrun[i_pad_idx] <= rrun_mid;
            end else if (fall) begin
                r_hrun[i_pad_idx] <= 1'b0;
                r_rrun[i_pad_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && (rise || held)) begin
            r_hold[i_pad_idx] <= n_hold;
        end
        if (i_load && held) begin
            r_rep[i_pad_idx] <= n_rep;
        end
    end

endmodule

// ===== rtl/bpr_merge.sv =====
// Merge stage: gathers lane events into masks and holds the output transaction.
module bpr_merge (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    output logic                                          o_load,
    input  logic [bpr_pkg::PAD_W-1:0]                     i_pad,
    input  bpr_pkg::t_lane_ev [bpr_pkg::BUTTON_COUNT-1:0] i_ev,
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    output logic [bpr_pkg::OUT_W-1:0]                     o_m_tdata,
    output logic [bpr_pkg::PAD_W-1:0]                     o_m_tuser
);

    logic                          r_valid;
    logic [bpr_pkg::PAD_W-1:0]     r_pad;
    logic [bpr_pkg::OUT_BITS-1:0]  r_data;
    logic [bpr_pkg::OUT_BITS-1:0]  n_data;
    logic [bpr_pkg::MASK_W-1:0]    push_m, press_m, long_m, rep_m, rel_m;
    logic                          any_ev;

    always_comb begin
        push_m  = '0;
        press_m = '0;
        long_m  = '0;
        rep_m   = '0;
        rel_m   = '0;
        for (int b = 0; b < bpr_pkg::OUT_LANES; b++) begin
            push_m[b]  = i_ev[b].push;
            press_m[b] = i_ev[b].press;
            long_m[b]  = i_ev[b].long_press;
            rep_m[b]   = i_ev[b].repeat_hit;
            rel_m[b]   = i_ev[b].release_hit;
        end
        any_ev = |{push_m, press_m, long_m, rep_m, rel_m};
        n_data = {any_ev, rel_m, rep_m, long_m, press_m, push_m};
    end

    assign o_ready = ~r_valid | i_m_tready;
    assign o_load  = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_pad  <= i_pad;
            r_data <= n_data;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_pad;
    assign o_m_tdata  = bpr_pkg::OUT_W'(r_data);

endmodule

// ===== rtl/button_press_repeat_events_core.sv =====
// Top level: press, long-press and auto-repeat events for virtual pads.
//
//  channel  | direction | handshake              | contents
//  ---------+-----------+------------------------+-------------------------------
//  s_axis   | in        | i_s_tvalid/o_s_tready  | pad update (mask, elapsed)
//  m_axis   | out       | o_m_tvalid/i_m_tready  | event masks for that pad
//  cfg      | in        | i_cfg_valid/o_cfg_ready| long-press time, repeat interval
//
//  One transaction per cycle unless the output stalls; each result is computed
//  by the single lane add/compare stage and held in the output register.
//  Synchronous active-low reset clears pad history, timer run flags and the
//  output valid flag; config returns to 500 / 100. A stalled output holds its
//  transaction and input is taken again as soon as that transaction leaves.
module button_press_repeat_events_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [bpr_pkg::IN_W-1:0]            i_s_tdata,  // pressed_mask, elapsed_ticks
    input  logic [bpr_pkg::PAD_W-1:0]           i_s_tuser,  // pad_select
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // push_mask, press_mask, long_press_mask, repeat_mask, release_mask, any_event
    output logic [bpr_pkg::OUT_W-1:0]           o_m_tdata,
    output logic [bpr_pkg::PAD_W-1:0]           o_m_tuser,  // pad_echo
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bpr_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [bpr_pkg::CFG_W-1:0]           i_cfg_data
);

    logic [bpr_pkg::CFG_W-1:0]                r_long_time;
    logic [bpr_pkg::CFG_W-1:0]                r_rep_int;
    logic                                     load;
    logic                                     pad_ok;
    logic [bpr_pkg::PAD_IDX_W-1:0]            pad_idx;
    logic [bpr_pkg::BUTTON_COUNT-1:0]         now_bits;
    logic [bpr_pkg::DT_W-1:0]                 dt;
    bpr_pkg::t_lane_ev [bpr_pkg::BUTTON_COUNT-1:0] lane_ev;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_time <= bpr_pkg::LONG_PRESS_RESET;
            r_rep_int   <= bpr_pkg::REPEAT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpr_pkg::REG_LONG_PRESS_TIME: r_long_time <= i_cfg_data;
                bpr_pkg::REG_REPEAT_INTERVAL: r_rep_int   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pad_ok  = (32'(i_s_tuser) < bpr_pkg::PAD_COUNT);
    assign pad_idx = pad_ok ? bpr_pkg::PAD_IDX_W'(i_s_tuser) : '0;
    assign dt      = i_s_tdata[bpr_pkg::MASK_W +: bpr_pkg::DT_W];

    for (genvar gi = 0; gi < bpr_pkg::BUTTON_COUNT; gi++) begin : g_lane
        if (gi < bpr_pkg::IN_LANES) begin : g_in
            assign now_bits[gi] = i_s_tdata[gi];
        end else begin : g_zero
            assign now_bits[gi] = 1'b0;
        end

        bpr_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (load),
            .i_pad_ok    (pad_ok),
            .i_pad_idx   (pad_idx),
            .i_now       (now_bits[gi]),
            .i_dt        (dt),
            .i_long_time (r_long_time),
            .i_rep_int   (r_rep_int),
            .o_ev        (lane_ev[gi])
        );
    end

    bpr_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .o_load     (load),
        .i_pad      (i_s_tuser),
        .i_ev       (lane_ev),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for button_press_repeat_events_core against a local event predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        pad;
        logic [15:0] mask;
        logic [7:0]  dt;
    } t_pad_update;

    typedef struct packed {
        logic        pad;
        logic [15:0] push_mask;
        logic [15:0] press_mask;
        logic [15:0] long_mask;
        logic [15:0] repeat_mask;
        logic [15:0] release_mask;
        logic        any_event;
    } t_pad_events;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_s_tvalid = 1'b0;
    logic                        o_s_tready;
    logic [bpr_pkg::IN_W-1:0]    i_s_tdata = '0;
    logic [bpr_pkg::PAD_W-1:0]   i_s_tuser = '0;
    logic                        o_m_tvalid;
    logic                        i_m_tready = 1'b0;
    logic [bpr_pkg::OUT_W-1:0]   o_m_tdata;
    logic [bpr_pkg::PAD_W-1:0]   o_m_tuser;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [bpr_pkg::IDX_W-1:0]   i_cfg_index = '0;
    logic [bpr_pkg::CFG_W-1:0]   i_cfg_data = '0;

    button_press_repeat_events_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_pad_update pending_updates[$];
    t_pad_events expected_events[$];
    t_pad_update next_update;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          mismatches = 0;
    int          tx_idle_pct = 10;
    int          rx_idle_pct = 72;
    int          rx_hold = 0;
    bit          s_taken = 1'b0;
    logic [15:0] stim_mask [2] = '{16'h0000, 16'h0000};

    logic [15:0] hold_limit = bpr_pkg::LONG_PRESS_RESET;
    logic [15:0] repeat_limit = bpr_pkg::REPEAT_RESET;
    logic [15:0] last_mask [2] = '{16'h0000, 16'h0000};
    logic [15:0] hold_run [2] = '{16'h0000, 16'h0000};
    logic [15:0] rep_run [2] = '{16'h0000, 16'h0000};
    logic [15:0] hold_cnt [2][16];
    logic [15:0] rep_cnt [2][16];

    initial begin
        for (int p = 0; p < 2; p++) begin
            for (int b = 0; b < 16; b++) begin
                hold_cnt[p][b] = '0;
                rep_cnt[p][b] = '0;
            end
        end
    end

    function automatic logic [15:0] sat_add(logic [15:0] count, logic [7:0] delta);
        logic [16:0] sum;
        sum = {1'b0, count} + {9'd0, delta};
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    function automatic t_pad_events predict_update(logic pad, logic [15:0] mask,
                                                   logic [7:0] dt);
        t_pad_events ev;
        logic [15:0] prev;
        logic [15:0] hrun;
        logic [15:0] rrun;
        ev = '0;
        ev.pad = pad;
        prev = last_mask[pad];
        hrun = hold_run[pad];
        rrun = rep_run[pad];
        for (int b = 0; b < 16; b++) begin
            if (!prev[b] && mask[b]) begin
                ev.push_mask[b] = 1'b1;
                ev.press_mask[b] = 1'b1;
                hrun[b] = 1'b1;
                hold_cnt[pad][b] = '0;
            end else if (prev[b] && mask[b]) begin
                ev.press_mask[b] = 1'b1;
                if (hrun[b])
                    hold_cnt[pad][b] = sat_add(hold_cnt[pad][b], dt);
                if (rrun[b])
                    rep_cnt[pad][b] = sat_add(rep_cnt[pad][b], dt);
                if (hrun[b] && hold_cnt[pad][b] >= hold_limit) begin
                    ev.long_mask[b] = 1'b1;
                    hrun[b] = 1'b0;
                    rrun[b] = 1'b1;
                    rep_cnt[pad][b] = '0;
                end
                if (rrun[b] && rep_cnt[pad][b] >= repeat_limit) begin
                    ev.repeat_mask[b] = 1'b1;
                    rep_cnt[pad][b] = '0;
                end
            end else if (prev[b] && !mask[b]) begin
                ev.release_mask[b] = 1'b1;
                hrun[b] = 1'b0;
                rrun[b] = 1'b0;
            end
        end
        last_mask[pad] = mask;
        hold_run[pad] = hrun;
        rep_run[pad] = rrun;
        ev.any_event = |{ev.push_mask, ev.press_mask, ev.long_mask, ev.repeat_mask,
                         ev.release_mask};
        return ev;
    endfunction

    function automatic void compare_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s at %0t: expected %h, got %h", what, $realtime,
                         want, got);
        end
    endfunction

    // driver: hold an offered transaction until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_taken) begin
            if (pending_updates.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_update = pending_updates.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {next_update.dt, next_update.mask};
                i_s_tuser <= next_update.pad;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            i_m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_pad_events want;
        s_taken = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                s_taken = 1'b1;
                n_accepted++;
                expected_events.push_back(predict_update(i_s_tuser[0], i_s_tdata[15:0],
                                                         i_s_tdata[23:16]));
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t: tuser %h tdata %h", $realtime,
                                 o_m_tuser, o_m_tdata);
                end else begin
                    want = expected_events.pop_front();
                    compare_field("pad_echo", {15'd0, want.pad}, {15'd0, o_m_tuser[0]});
                    compare_field("push_mask", want.push_mask, o_m_tdata[15:0]);
                    compare_field("press_mask", want.press_mask, o_m_tdata[31:16]);
                    compare_field("long_press_mask", want.long_mask, o_m_tdata[47:32]);
                    compare_field("repeat_mask", want.repeat_mask, o_m_tdata[63:48]);
                    compare_field("release_mask", want.release_mask, o_m_tdata[79:64]);
                    compare_field("any_event", {15'd0, want.any_event},
                                  {15'd0, o_m_tdata[80]});
                end
            end
        end
    end

    task automatic queue_one(int pad, logic [15:0] mask, logic [7:0] dt);
        pending_updates.push_back('{pad[0], mask, dt});
        n_queued++;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || expected_events.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [bpr_pkg::IDX_W-1:0] idx, logic [bpr_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == bpr_pkg::REG_LONG_PRESS_TIME)
            hold_limit = value;
        else
            repeat_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_updates(int count, int only_pad, int dt_lo, int dt_hi,
                                 int flip_odds, int noise_pct);
        int pad;
        int pick;
        logic [15:0] mask;
        logic [7:0] dt;
        for (int n = 0; n < count; n++) begin
            pad = (only_pad < 0) ? $urandom_range(1) : only_pad;
            for (int b = 0; b < 16; b++)
                if ($urandom_range(flip_odds - 1) == 0)
                    stim_mask[pad][b] = ~stim_mask[pad][b];
            mask = stim_mask[pad];
            if ($urandom_range(99) < noise_pct)
                mask = 16'($urandom_range(16'hFFFF));
            pick = $urandom_range(99);
            if (pick < 3)
                dt = 8'd0;
            else if (pick < 6)
                dt = 8'd255;
            else
                dt = 8'($urandom_range(dt_hi, dt_lo));
            queue_one(pad, mask, dt);
        end
    endtask

    task automatic run_phase(int lp, int ri, int count, int only_pad, int dt_lo, int dt_hi,
                             int flip_odds, int noise_pct, int hold_rx);
        write_reg(bpr_pkg::REG_LONG_PRESS_TIME, lp[15:0]);
        write_reg(bpr_pkg::REG_REPEAT_INTERVAL, ri[15:0]);
        queue_updates(count / 2, only_pad, dt_lo, dt_hi, flip_odds, noise_pct);
        if (hold_rx > 0) begin
            @(posedge i_clk);
            rx_hold = hold_rx;
        end
        wait_idle();
        queue_updates(count - count / 2, only_pad, dt_lo, dt_hi, flip_odds, noise_pct);
        wait_idle();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_one(0, 16'hFFFF, 8'd0);
        queue_one(1, 16'h0001, 8'd255);
        queue_one(0, 16'hFFFF, 8'd255);
        queue_one(0, 16'hFFFF, 8'd255);
        queue_one(0, 16'hFFFF, 8'd100);
        queue_one(0, 16'hAAAA, 8'd0);
        queue_one(0, 16'h0000, 8'd7);
        queue_one(1, 16'h0000, 8'd0);
        queue_one(0, 16'h0000, 8'd0);
        wait_idle();
        write_reg(bpr_pkg::REG_LONG_PRESS_TIME, 16'd0);
        write_reg(bpr_pkg::REG_REPEAT_INTERVAL, 16'd0);
        queue_one(1, 16'h8001, 8'd0);
        queue_one(1, 16'h8001, 8'd0);
        queue_one(1, 16'h8001, 8'd1);
        queue_one(1, 16'h0000, 8'd0);
        wait_idle();

        run_phase(500, 100, 350, -1, 1, 80, 40, 5, 300);
        run_phase(0, 0, 300, -1, 0, 20, 8, 5, 0);
        tx_idle_pct = 72;
        rx_idle_pct = 10;
        run_phase(65535, 65535, 700, 0, 200, 255, 2000, 0, 0);
        run_phase(30, 7, 350, -1, 0, 15, 30, 5, 0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase($urandom_range(600), $urandom_range(150), 300, -1, 0, 60, 25, 5, 0);
        run_phase(255, 1, 200, -1, 0, 255, 20, 10, 0);

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
